### src/pwrcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pwrcd_pkg;

   // Phase encoding: 0 .. parts-1 are code parts, parts is the trailing
   // short pulse, anything above but PHASE_IDLE is the closing sync check.
   localparam logic [7:0] PHASE_IDLE = 8'hFF;
   localparam logic [7:0] PHASE_FIRST = 8'd0;
   localparam logic [7:0] PARTS_TRI = 8'd48;
   localparam logic [7:0] PARTS_BIN = 8'd128;

   localparam logic [15:0] SYNC_THR_TRI = 16'd3720;

   // floor(d / 31) == (d * RECIP_31) >> RECIP_31_SHIFT for every 16-bit d
   localparam logic [16:0] RECIP_31 = 17'd67651;
   localparam int unsigned RECIP_31_SHIFT = 21;

   localparam logic [12:0] PERIOD_MIN_BIN = 13'd320;
   localparam logic [12:0] PERIOD_MAX_BIN = 13'd450;

   localparam logic [3:0] PAT_TRI_ZERO = 4'b1010;
   localparam logic [3:0] PAT_TRI_ONE = 4'b0101;
   localparam logic [3:0] PAT_TRI_FLOAT = 4'b0110;
   localparam logic [3:0] PAT_BIN_ZERO = 4'b1000;
   localparam logic [3:0] PAT_BIN_ONE = 4'b0010;

   localparam logic [1:0] SYM_ZERO = 2'd0;
   localparam logic [1:0] SYM_ONE = 2'd1;
   localparam logic [1:0] SYM_FLOAT = 2'd2;

   localparam logic [1:0] REG_DECODE_MODE = 2'd0;
   localparam logic [1:0] REG_MIN_REPEATS = 2'd1;
   localparam logic [1:0] REG_EST_SYNC_WIDTH = 2'd2;

   localparam logic [7:0] REPEAT_MAX = 8'd255;

   // Width class of one interval against the current unit period.
   typedef struct packed {
      logic is_short;
      logic is_long;
      logic sync_ok;
   } width_class_type;

endpackage

`default_nettype wire

### src/pwrcd_classify.sv
`timescale 1ns / 1ps
`default_nettype none

// Classify an interval as short, long or closing sync. The floor(p*k/10)
// limits are compared as 10*d against p*k, so no divider is needed.
module pwrcd_classify (
   input  wire logic [15:0]               interval_us,
   input  wire logic [12:0]               period,
   input  wire logic                      decode_mode,
   output pwrcd_pkg::width_class_type     width_class
);

   logic [19:0] d_wide;
   logic [19:0] d_x10;
   logic [19:0] d_x10_up;
   logic [19:0] p_wide;
   logic [19:0] p_x4;
   logic [19:0] p_x16;
   logic [19:0] p_x23;
   logic [19:0] p_x37;
   logic [19:0] p_x47;
   logic [19:0] p_max3;
   logic [19:0] p_x25;
   logic [19:0] p_x36;

   assign d_wide = {4'd0, interval_us};
   assign d_x10 = (d_wide << 3) + (d_wide << 1);
   assign d_x10_up = d_x10 + 20'd10;

   assign p_wide = {7'd0, period};
   assign p_x4 = p_wide << 2;
   assign p_x16 = p_wide << 4;
   assign p_x23 = p_x16 + p_x4 + (p_wide << 1) + p_wide;
   assign p_x37 = (p_wide << 5) + p_x4 + p_wide;
   assign p_x47 = (p_wide << 5) + p_x16 - p_wide;
   assign p_x25 = p_x16 + (p_wide << 3) + p_wide;
   assign p_x36 = (p_wide << 5) + p_x4;
   assign p_max3 = decode_mode ? p_x47 : p_x37;

   // d >= floor(x/10) <=> 10d + 10 > x ; d <= floor(x/10) <=> 10d <= x
   assign width_class.is_short = (d_x10_up > p_x4) && (d_x10 <= p_x16);
   assign width_class.is_long = (d_x10_up > p_x23) && (d_x10 <= p_max3);
   assign width_class.sync_ok = (d_wide >= p_x25) && (d_wide <= p_x36);

endmodule

`default_nettype wire

### src/pulse_width_remote_code_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Pulse-width remote code decoder. Each req transaction carries the time in
// microseconds between successive edges of the received signal; each one yields
// exactly one rsp transaction. The block waits for a long sync interval,
// takes the unit period from it (interval/31 in tristate mode, interval/8
// accepted only in 320..450 in binary mode), then classes the following intervals
// as short or long, four to a symbol, and shifts the symbols into a code.
// After the trailing short pulse and a 25..36 period sync, a code seen
// min_repeats times in a row is reported with code_valid set, along with
// its unit period; receiving shows whether the decoder is inside a frame.
// Rate: one transaction per clock cycle, sustained while rsp_ready is high.
// A transaction passes the input register, then the single-pass decode into
// the result register, which is also where all decoder state is updated.
// Configuration writes take effect at the next edge; write them only while
// no transaction is in flight.
module pulse_width_remote_code_decoder (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_interval_us,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_code_valid,
   output logic [31:0]      rsp_code_value,
   output logic [12:0]      rsp_unit_period,
   output logic             rsp_receiving,

   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   // configuration
   logic        decode_mode_ff;
   logic [7:0]  min_repeats_ff;
   logic [15:0] est_sync_width_ff;

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [15:0] in_interval_ff;

   // decoder state
   logic [7:0]  phase_ff, phase_in;
   logic [3:0]  part_bits_ff, part_bits_in;
   logic [31:0] code_acc_ff, code_acc_in;
   logic [31:0] last_code_ff, last_code_in;
   logic [7:0]  repeat_count_ff, repeat_count_in;
   logic [12:0] period_ff, period_in;

   // result register
   logic        out_valid_ff, out_valid_in;
   logic        out_code_valid_ff, out_code_valid_in;
   logic [31:0] out_code_value_ff, out_code_value_in;
   logic [12:0] out_period_ff, out_period_in;
   logic        out_receiving_ff, out_receiving_in;

   logic        advance;
   pwrcd_pkg::width_class_type width_class;

   logic [7:0]  parts;
   logic [15:0] sync_thr;
   logic [32:0] recip_prod;
   logic [12:0] new_period;
   logic        period_ok;
   logic [3:0]  part_mask;
   logic [3:0]  bits_next;
   logic [1:0]  sym;
   logic        sym_ok;
   logic [31:0] acc_shifted;
   logic [7:0]  rep_base;
   logic [7:0]  rep_next;

   pwrcd_classify u_classify (
      .interval_us (in_interval_ff),
      .period      (period_ff),
      .decode_mode (decode_mode_ff),
      .width_class (width_class)
   );

   // Decode one transaction when the result register is free or draining.
   assign advance = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign in_valid_in = req_valid ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   assign parts = decode_mode_ff ? pwrcd_pkg::PARTS_BIN : pwrcd_pkg::PARTS_TRI;
   assign sync_thr = decode_mode_ff ? est_sync_width_ff : pwrcd_pkg::SYNC_THR_TRI;

   // Unit period from the start sync: shift in binary mode, reciprocal in
   // tristate mode.
   assign recip_prod = {17'd0, in_interval_ff} * {16'd0, pwrcd_pkg::RECIP_31};
   assign new_period = decode_mode_ff ? in_interval_ff[15:3]
                                      : {1'b0, recip_prod[32:pwrcd_pkg::RECIP_31_SHIFT]};
   assign period_ok = !decode_mode_ff ||
                      ((new_period >= pwrcd_pkg::PERIOD_MIN_BIN) &&
                       (new_period <= pwrcd_pkg::PERIOD_MAX_BIN));

   // Part bit k is set by a long interval, cleared by a short one.
   assign part_mask = 4'b0001 << phase_ff[1:0];
   assign bits_next = width_class.is_short ? (part_bits_ff & ~part_mask)
                                           : (part_bits_ff | part_mask);

   // Map the four parts to a symbol.
   always_comb begin
      sym = pwrcd_pkg::SYM_ZERO;
      sym_ok = 1'b0;
      if (decode_mode_ff) begin
         case (bits_next)
            pwrcd_pkg::PAT_BIN_ZERO: begin
               sym = pwrcd_pkg::SYM_ZERO;
               sym_ok = 1'b1;
            end
            pwrcd_pkg::PAT_BIN_ONE: begin
               sym = pwrcd_pkg::SYM_ONE;
               sym_ok = 1'b1;
            end
            default: begin
               sym = pwrcd_pkg::SYM_ZERO;
               sym_ok = 1'b0;
            end
         endcase
      end else begin
         case (bits_next)
            pwrcd_pkg::PAT_TRI_ZERO: begin
               sym = pwrcd_pkg::SYM_ZERO;
               sym_ok = 1'b1;
            end
            pwrcd_pkg::PAT_TRI_ONE: begin
               sym = pwrcd_pkg::SYM_ONE;
               sym_ok = 1'b1;
            end
            pwrcd_pkg::PAT_TRI_FLOAT: begin
               sym = pwrcd_pkg::SYM_FLOAT;
               sym_ok = 1'b1;
            end
            default: begin
               sym = pwrcd_pkg::SYM_ZERO;
               sym_ok = 1'b0;
            end
         endcase
      end
   end

   // Base 3 or base 2 shift; wraps at 32 bits.
   assign acc_shifted = decode_mode_ff ? (code_acc_ff << 1)
                                       : ((code_acc_ff << 1) + code_acc_ff);

   // Repeat counting: restart on a new code, saturate at the top.
   assign rep_base = (code_acc_ff == last_code_ff) ? repeat_count_ff : 8'd0;
   assign rep_next = (rep_base < pwrcd_pkg::REPEAT_MAX) ? (rep_base + 8'd1) : rep_base;

   always_comb begin
      phase_in = phase_ff;
      part_bits_in = part_bits_ff;
      code_acc_in = code_acc_ff;
      last_code_in = last_code_ff;
      repeat_count_in = repeat_count_ff;
      period_in = period_ff;
      out_code_valid_in = out_code_valid_ff;
      out_code_value_in = out_code_value_ff;
      out_period_in = out_period_ff;
      out_receiving_in = out_receiving_ff;

      if (advance) begin
         out_code_valid_in = 1'b0;
         out_code_value_in = 32'd0;
         out_period_in = 13'd0;

         if (phase_ff == pwrcd_pkg::PHASE_IDLE) begin
            // wait for the start sync
            if ((in_interval_ff > sync_thr) && period_ok) begin
               period_in = new_period;
               code_acc_in = 32'd0;
               if (!decode_mode_ff) begin
                  last_code_in = 32'd0;
                  repeat_count_in = 8'd0;
               end
               phase_in = pwrcd_pkg::PHASE_FIRST;
            end
         end else if (phase_ff < parts) begin
            // one code part
            if (!width_class.is_short && !width_class.is_long) begin
               phase_in = pwrcd_pkg::PHASE_IDLE;
            end else begin
               part_bits_in = bits_next;
               if (phase_ff[1:0] == 2'd3) begin
                  code_acc_in = acc_shifted + {30'd0, sym};
                  phase_in = sym_ok ? (phase_ff + 8'd1) : pwrcd_pkg::PHASE_IDLE;
               end else begin
                  phase_in = phase_ff + 8'd1;
               end
            end
         end else if (phase_ff == parts) begin
            // trailing short pulse
            phase_in = width_class.is_short ? (phase_ff + 8'd1) : pwrcd_pkg::PHASE_IDLE;
         end else begin
            // closing sync
            if (!width_class.sync_ok) begin
               phase_in = pwrcd_pkg::PHASE_IDLE;
            end else begin
               last_code_in = code_acc_ff;
               repeat_count_in = rep_next;
               if (rep_next >= min_repeats_ff) begin
                  out_code_valid_in = 1'b1;
                  out_code_value_in = code_acc_ff;
                  out_period_in = period_ff;
                  phase_in = pwrcd_pkg::PHASE_IDLE;
               end else begin
                  code_acc_in = 32'd0;
                  phase_in = decode_mode_ff ? pwrcd_pkg::PHASE_IDLE
                                            : pwrcd_pkg::PHASE_FIRST;
               end
            end
         end

         out_receiving_in = (phase_in != pwrcd_pkg::PHASE_IDLE);
      end
   end

   // Hold the result until it is taken; load a new one on advance.
   assign out_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         decode_mode_ff <= 1'b0;
         min_repeats_ff <= 8'd2;
         est_sync_width_ff <= 16'd1920;
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff <= pwrcd_pkg::PHASE_IDLE;
         part_bits_ff <= 4'd0;
         code_acc_ff <= 32'd0;
         last_code_ff <= 32'd0;
         repeat_count_ff <= 8'd0;
         period_ff <= 13'd0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               pwrcd_pkg::REG_DECODE_MODE: decode_mode_ff <= csr_wdata[0];
               pwrcd_pkg::REG_MIN_REPEATS: min_repeats_ff <= csr_wdata[7:0];
               pwrcd_pkg::REG_EST_SYNC_WIDTH: est_sync_width_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         phase_ff <= phase_in;
         part_bits_ff <= part_bits_in;
         code_acc_ff <= code_acc_in;
         last_code_ff <= last_code_in;
         repeat_count_ff <= repeat_count_in;
         period_ff <= period_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_interval_ff <= req_interval_us;
      end
      out_code_valid_ff <= out_code_valid_in;
      out_code_value_ff <= out_code_value_in;
      out_period_ff <= out_period_in;
      out_receiving_ff <= out_receiving_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_code_valid = out_code_valid_ff;
   assign rsp_code_value = out_code_value_ff;
   assign rsp_unit_period = out_period_ff;
   assign rsp_receiving = out_receiving_ff;

endmodule

`default_nettype wire
